[hdl/bist_pkg.sv]
// Package for the bounded integer set table: item types, operation codes,
// state encoding and per-cell control. No dependencies.
package bist_pkg;

  // Default table capacity
  localparam int unsigned DEFAULT_SET_CAPACITY = 32;

  // Width of the count field of a result item
  localparam int unsigned COUNT_W = 6;

  // Operation codes; the unused code acts as a query
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // Input item
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_t;

  // Result item
  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               full_drop;
  } out_t;

  // Control broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;   // latch match against the arriving value
    logic append;   // write the key into the cell at the end of the table
    logic remove;   // shift down every cell at or above the match
  } cell_ctrl_t;

endpackage

[hdl/bounded_integer_set_table.sv]
// Top level of the bounded integer set table: controller, count register,
// result register and a chain of bist_cell entries. Uses bist_pkg.
//
//   channel | signals                          | payload
//   --------+----------------------------------+----------------------------
//   input   | in_valid_i, in_ready_o           | in_data_i  (kind, value)
//   result  | out_valid_o, out_ready_i         | out_data_o (was_present,
//           |                                  |   count, is_empty, full_drop)
//
// For each item, every cell compares the value at acceptance; then, in the
// update state, the match flag ripples up the cell chain, the table
// is updated (append at the tail or shift down above the match) and the
// result is written to the output register.
// Reset clears the count; entry contents are not cleared and need no pass.
// The update cycle waits while an earlier result is still held by the sink.
module bounded_integer_set_table
  import bist_pkg::*;
#(
  parameter int unsigned SetCapacity = DEFAULT_SET_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CntW = $clog2(SetCapacity + 1);

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [1:0]         kind_q;
  logic signed [31:0] key_q;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;
  cell_ctrl_t         ctrl;
  logic               in_fire, upd_fire, present, full;

  logic signed [31:0] cell_value [SetCapacity];
  logic               shift_chain [SetCapacity+1];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);
  assign present    = shift_chain[SetCapacity];
  assign full       = (count_q == CntW'(SetCapacity));

  // Chain of entry cells
  assign shift_chain[0] = 1'b0;
  for (genvar i = 0; i < SetCapacity; i++) begin : g_cell
    logic signed [31:0] next_value;
    if (i == SetCapacity - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end
    bist_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_value_i  (in_data_i.value),
      .key_i        (key_q),
      .occupied_i   (CntW'(i) < count_q),
      .tail_i       (CntW'(i) == count_q),
      .next_value_i (next_value),
      .shift_i      (shift_chain[i]),
      .shift_o      (shift_chain[i+1]),
      .value_o      (cell_value[i])
    );
  end

  // Next state, cell control, count and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ctrl        = '0;
    ctrl.cmp_en = in_fire;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          out_d.full_drop = 1'b0;
          case (kind_q)
            KIND_ADD: begin
              if (!present) begin
                if (full) begin
                  out_d.full_drop = 1'b1;
                end else begin
                  ctrl.append = 1'b1;
                  count_d     = count_q + CntW'(1);
                end
              end
            end
            KIND_REMOVE: begin
              if (present) begin
                ctrl.remove = 1'b1;
                count_d     = count_q - CntW'(1);
              end
            end
            default: begin
              // query and the unused code leave the table unchanged
            end
          endcase
          out_d.was_present = present;
          out_d.count       = COUNT_W'(count_d);
          out_d.is_empty    = (count_d == '0);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the item in progress and the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_data_i.kind;
      key_q  <= in_data_i.value;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/bist_cell.sv]
// One entry of the set table: holds a value, matches it against the key
// and takes its upper neighbor's value on removal. Uses bist_pkg.
module bist_cell
  import bist_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] cmp_value_i,   // value of the arriving item
  input  logic signed [31:0] key_i,         // value of the item in progress
  input  logic               occupied_i,    // entry lies below the count
  input  logic               tail_i,        // entry is the first free slot
  input  logic signed [31:0] next_value_i,  // value held by the upper neighbor
  input  logic               shift_i,       // a match sits in a lower cell
  output logic               shift_o,       // a match sits here or below
  output logic signed [31:0] value_o
);

  logic signed [31:0] value_q, value_d;
  logic               hit_q, hit_d;

  // Latch the match when an item arrives; only occupied entries count
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = occupied_i && (value_q == cmp_value_i);
    end
  end

  // Hand the match flag on to the upper neighbor
  assign shift_o = shift_i | hit_q;

  // Append at the tail, or pull the neighbor down above a removed match
  always_comb begin
    value_d = value_q;
    if (ctrl_i.append && tail_i) begin
      value_d = key_i;
    end else if (ctrl_i.remove && shift_o) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
